// ===== sv/ctre_pkg.sv =====
`default_nettype none
package ctre_pkg;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int SEQ_STEP_DEF    = 2;

    localparam logic [5:0] NODE_MASK    = 6'h3F;
    localparam logic [31:0] RESP_OFFSET = 32'd1;

    localparam logic [2:0] MODE_SUBMIT = 3'd0;
    localparam logic [2:0] MODE_WDONE  = 3'd1;
    localparam logic [2:0] MODE_TICK   = 3'd2;
    localparam logic [2:0] MODE_RESP   = 3'd3;
    localparam logic [2:0] MODE_CANCEL = 3'd4;

    localparam logic [2:0] WR_OK      = 3'd0;
    localparam logic [2:0] WR_TIMEOUT = 3'd1;
    localparam logic [2:0] WR_BUSY    = 3'd2;
    localparam logic [2:0] WR_STALE   = 3'd3;
    localparam logic [2:0] WR_ABORTED = 3'd4;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_CMPL = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_NOTREADY = 4'd1;
    localparam logic [3:0] ST_TIMEOUT  = 4'd2;
    localparam logic [3:0] ST_ABORTED  = 4'd4;
    localparam logic [3:0] ST_IOERR    = 4'd5;
    localparam logic [3:0] ST_MISMATCH = 4'd6;
    localparam logic [3:0] ST_DEVERR   = 4'd7;
    localparam logic [3:0] ST_FULL     = 4'd8;
    localparam logic [3:0] ST_STALE    = 4'd3;

    localparam logic [1:0] CFG_ROUTE_VALID = 2'd0;
    localparam logic [1:0] CFG_ROUTE_NODE  = 2'd1;
    localparam logic [1:0] CFG_MAX_ATT     = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  category;
        logic [31:0] command;
        logic [2:0]  write_result;
        logic [31:0] serial_tag;
        logic [15:0] source_node;
        logic [31:0] resp_seqnum;
        logic [7:0]  resp_category;
        logic [31:0] resp_command;
        logic [31:0] resp_status;
        logic [3:0]  cancel_status;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seqnum;
        logic [7:0]  out_category;
        logic [31:0] out_command;
        logic [5:0]  target_node;
        logic [3:0]  attempt;
        logic [31:0] send_serial;
        logic [3:0]  status;
        logic        accepted;
        logic        last;
    } t_out_item;
endpackage
`default_nettype wire

// ===== sv/ctre_if.sv =====
`default_nettype none
interface ctre_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ctre_ram.sv =====
`default_nettype none
module ctre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/command_transaction_retry_engine_core.sv =====
`default_nettype none
// Command transaction retry engine. Commands enter a queue held in a
// synchronous RAM (seqnum + category/command per entry); one command is in
// flight at a time and is resent on write timeout, busy, or tick timeout
// until max_attempts. Each input item yields one or more result items on
// the output channel, the final one flagged by last; an item that causes no
// send or completion yields one acknowledgement. A new input item is taken
// only in S_IDLE, after the previous one has finished. Every queue entry
// that is read back (started, completed as not_ready, or cancelled) goes
// through address, pop and hand-off steps, since the single RAM read port
// is registered; cancel reads back every queued entry in this way. A
// stalled output holds the engine until its result is taken. The user must
// write configuration through the plain write port only while the block is
// idle; the block itself does not enforce this.
module command_transaction_retry_engine_core #(
    parameter int QUEUE_DEPTH = ctre_pkg::QUEUE_DEPTH_DEF,
    parameter int SEQ_STEP    = ctre_pkg::SEQ_STEP_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    ctre_if.sink             in_ch,
    ctre_if.source           out_ch
);
    import ctre_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RD = (QUEUE_DEPTH > 1) ? QUEUE_DEPTH : 2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_RD    = 6'b000100,
        S_POP   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    // configuration
    logic        r_route_valid;
    logic [5:0]  r_route_node;
    logic [3:0]  r_max_att;
    logic [15:0] r_tmo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_valid <= 1'b0;
            r_route_node  <= '0;
            r_max_att     <= 4'd3;
            r_tmo         <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROUTE_VALID: r_route_valid <= i_cfg_data[0];
                CFG_ROUTE_NODE:  r_route_node  <= i_cfg_data[5:0];
                CFG_MAX_ATT:     r_max_att     <= i_cfg_data[3:0];
                CFG_TIMEOUT:     r_tmo         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state      r_state;
    t_in_item    r_in;
    t_out_item   r_out;
    logic        r_ovalid;
    logic        r_acc;
    logic        r_cancel;   // draining queue for cancel
    logic [3:0]  r_cs;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic        r_busy;
    logic [31:0] r_bseq;
    logic [39:0] r_bcc;
    logic [3:0]  r_batt;
    logic [31:0] r_bser;
    logic [31:0] r_sctr;
    logic [31:0] r_seqctr;
    logic        r_tarm;
    logic [15:0] r_tcnt;

    // pending result buffer: the next result to go
    t_out_item   r_pend;

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [71:0]   ram_wdata, ram_rdata;

    ctre_ram #(.WIDTH(72), .DEPTH(RD)) u_qram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        if (QUEUE_DEPTH == 1) return '0;
        if (a == AW'(QUEUE_DEPTH - 1)) return '0;
        return a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] tail_idx(input logic [AW-1:0] h,
                                              input logic [CW-1:0] c);
        logic [AW+CW:0] s;
        s = (AW+CW+1)'(h) + (AW+CW+1)'(c);
        if (s >= (AW+CW+1)'(QUEUE_DEPTH)) s = s - (AW+CW+1)'(QUEUE_DEPTH);
        return s[AW-1:0];
    endfunction

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    wire out_free = !r_ovalid || out_ch.ready;

    // results: a result is staged in r_pend; it is pushed to r_out with
    // last decided when the item's processing finishes (S_WAIT holds pend).
    logic        r_hpend;

    // another result follows the staged one
    logic        more_pend;
    logic        do_push;

    assign more_pend = r_cancel ? (r_count != '0) : (!r_busy && r_count != '0);
    assign do_push   = out_free && ((r_state == S_EMIT) ||
                                    ((r_state == S_WAIT) && more_pend));

    function automatic t_out_item mk(input logic [1:0] k, input logic [31:0] s,
                                     input logic [39:0] cc, input logic [5:0] n,
                                     input logic [3:0] a, input logic [31:0] ser,
                                     input logic [3:0] st);
        t_out_item o;
        o.kind = k; o.seqnum = s; o.out_category = cc[39:32];
        o.out_command = cc[31:0]; o.target_node = n; o.attempt = a;
        o.send_serial = ser; o.status = st; o.accepted = 1'b0; o.last = 1'b0;
        return o;
    endfunction

    function automatic t_out_item with_tail(input t_out_item o, input logic acc,
                                            input logic lst);
        t_out_item t;
        t = o;
        t.accepted = acc;
        t.last = lst;
        return t;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (do_push) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Staging: a new result can be added only if out_free or no pending.
    // Engine holds in S_WAIT or S_EMIT until a staged result flushes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hpend  <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
            r_busy   <= 1'b0;
            r_bseq   <= '0;
            r_bcc    <= '0;
            r_batt   <= '0;
            r_bser   <= '0;
            r_sctr   <= '0;
            r_seqctr <= '0;
            r_tarm   <= 1'b0;
            r_tcnt   <= '0;
            r_cancel <= 1'b0;
            r_acc    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_in     <= in_ch.data;
                        r_state  <= S_EXEC;
                        r_acc    <= 1'b0;
                        r_cancel <= 1'b0;
                    end
                end
                S_EXEC: begin
                    case (r_in.mode)
                        MODE_SUBMIT: begin
                            r_seqctr <= r_seqctr + 32'(SEQ_STEP);
                            if (r_count >= CW'(QUEUE_DEPTH)) begin
                                r_pend  <= mk(KIND_CMPL, r_seqctr,
                                    {r_in.category, r_in.command}, '0, '0, '0, ST_FULL);
                                r_hpend <= 1'b1;
                                r_state <= S_EMIT;
                            end else begin
                                r_count <= r_count + 1'b1;
                                r_state <= S_RD;   // try to start it
                            end
                        end
                        MODE_WDONE: begin
                            if (r_busy && r_in.serial_tag == r_bser) begin
                                case (r_in.write_result)
                                    WR_OK: begin
                                        r_tarm <= 1'b1; r_tcnt <= r_tmo;
                                        r_state <= S_RD;
                                    end
                                    WR_TIMEOUT, WR_BUSY: r_state <= S_POP; // retry
                                    default: begin
                                        r_busy <= 1'b0; r_tarm <= 1'b0; r_tcnt <= '0;
                                        r_pend <= mk(KIND_CMPL, r_bseq, r_bcc, '0, '0, '0,
                                            (r_in.write_result == WR_STALE) ? ST_STALE :
                                            (r_in.write_result == WR_ABORTED) ? ST_ABORTED :
                                            ST_IOERR);
                                        r_hpend <= 1'b1;
                                        r_state <= S_WAIT;
                                    end
                                endcase
                            end else r_state <= S_EMIT;
                        end
                        MODE_TICK: begin
                            if (r_busy && r_tarm) begin
                                if (r_tcnt <= 16'd1) begin
                                    r_tarm <= 1'b0; r_tcnt <= '0;
                                    r_state <= S_POP;
                                end else begin
                                    r_tcnt <= r_tcnt - 1'b1;
                                    r_state <= S_EMIT;
                                end
                            end else r_state <= S_EMIT;
                        end
                        MODE_RESP: begin
                            if (r_busy && r_route_valid &&
                                (r_in.source_node[5:0] & NODE_MASK) == r_route_node &&
                                r_in.resp_seqnum == r_bseq + RESP_OFFSET) begin
                                r_acc <= 1'b1;
                                r_busy <= 1'b0; r_tarm <= 1'b0; r_tcnt <= '0;
                                r_pend <= mk(KIND_CMPL, r_bseq, r_bcc, '0, '0, '0,
                                    ({r_in.resp_category, r_in.resp_command} != r_bcc)
                                        ? ST_MISMATCH :
                                    (r_in.resp_status != '0) ? ST_DEVERR : ST_OK);
                                r_hpend <= 1'b1;
                                r_state <= S_WAIT;
                            end else r_state <= S_EMIT;
                        end
                        MODE_CANCEL: begin
                            r_cancel <= 1'b1;
                            r_cs <= (r_in.cancel_status > ST_FULL) ? ST_ABORTED
                                                                   : r_in.cancel_status;
                            r_tarm <= 1'b0; r_tcnt <= '0;
                            if (r_busy) begin
                                r_busy <= 1'b0;
                                r_pend <= mk(KIND_CMPL, r_bseq, r_bcc, '0, '0, '0,
                                    (r_in.cancel_status > ST_FULL) ? ST_ABORTED
                                                                   : r_in.cancel_status);
                                r_hpend <= 1'b1;
                                r_state <= S_WAIT;
                            end else r_state <= S_RD;
                        end
                        default: r_state <= S_EMIT;
                    endcase
                end
                S_RD: begin
                    // read issued combinationally at head; data next cycle
                    if (r_cancel) begin
                        if (r_count == '0) begin
                            r_head <= '0;
                            r_state <= S_EMIT;
                        end else r_state <= S_POP;
                    end else if (!r_busy && r_count != '0) r_state <= S_POP;
                    else r_state <= S_EMIT;
                end
                S_POP: begin
                    if (r_cancel || !r_busy) begin
                        // dequeue head
                        r_head  <= wrap_inc(r_head);
                        r_count <= r_count - 1'b1;
                        if (r_cancel)
                            r_pend <= mk(KIND_CMPL, ram_rdata[71:40], ram_rdata[39:0],
                                '0, '0, '0, r_cs);
                        else if (!r_route_valid)
                            r_pend <= mk(KIND_CMPL, ram_rdata[71:40], ram_rdata[39:0],
                                '0, '0, '0, ST_NOTREADY);
                        else begin
                            r_busy <= 1'b1; r_bseq <= ram_rdata[71:40];
                            r_bcc <= ram_rdata[39:0]; r_batt <= 4'd1;
                            r_sctr <= r_sctr + 1'b1; r_bser <= r_sctr + 1'b1;
                            r_tarm <= 1'b0; r_tcnt <= '0;
                            r_pend <= mk(KIND_SEND, ram_rdata[71:40], ram_rdata[39:0],
                                r_route_node, 4'd1, r_sctr + 1'b1, ST_OK);
                        end
                    end else if (r_batt < r_max_att) begin
                        // resend in-flight command
                        r_batt <= r_batt + 1'b1;
                        r_sctr <= r_sctr + 1'b1; r_bser <= r_sctr + 1'b1;
                        r_tarm <= 1'b0; r_tcnt <= '0;
                        r_pend <= mk(KIND_SEND, r_bseq, r_bcc, r_route_node,
                            r_batt + 1'b1, r_sctr + 1'b1, ST_OK);
                    end else begin
                        r_busy <= 1'b0; r_tarm <= 1'b0; r_tcnt <= '0;
                        r_pend <= mk(KIND_CMPL, r_bseq, r_bcc, '0, '0, '0, ST_TIMEOUT);
                    end
                    r_hpend <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    // more results follow: send the staged one as non-last and
                    // go read the next entry; otherwise finish in S_EMIT
                    if (more_pend) begin
                        if (out_free) begin
                            r_out   <= with_tail(r_pend, r_acc, 1'b0);
                            r_hpend <= 1'b0;
                            r_state <= S_RD;
                        end
                    end else r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out <= with_tail(r_hpend ? r_pend
                                           : mk(KIND_ACK, '0, '0, '0, '0, '0, ST_OK),
                                           r_acc, 1'b1);
                        r_hpend <= 1'b0;
                        if (r_cancel) r_head <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // submit writes at tail in S_EXEC; reads always address head
    assign ram_we    = (r_state == S_EXEC) && (r_in.mode == MODE_SUBMIT) &&
                       (r_count < CW'(QUEUE_DEPTH));
    assign ram_waddr = tail_idx(r_head, r_count);
    assign ram_wdata = {r_seqctr, r_in.category, r_in.command};
    assign ram_raddr = r_head;
endmodule
`default_nettype wire

// ===== sv/ctre_checker.sv =====
`default_nettype none
module ctre_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire ctre_pkg::t_out_item out_data
);
    import ctre_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");
    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.kind == KIND_ACK |-> out_data.last && out_data.seqnum == '0)
        else $error("ack item malformed");
    a_send_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.kind == KIND_SEND |-> out_data.status == ST_OK &&
        out_data.attempt != '0)
        else $error("send item malformed");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous in progress");
endmodule

bind command_transaction_retry_engine_core ctre_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ===== tb/tb_command_transaction_retry_engine_core.sv =====
module tb_command_transaction_retry_engine_core;
    import ctre_pkg::*;

    localparam int QDEPTH    = QUEUE_DEPTH_DEF;
    localparam int STALL_MAX = 30;
    localparam int WDOG_MAX  = 4000;

    // Transaction engine predictor and the queue of results it expects.
    class retry_scoreboard;
        logic        rt_valid;
        logic [5:0]  rt_node;
        logic [3:0]  max_att;
        logic [15:0] tmo_ticks;
        logic [31:0] q_seq [QDEPTH];
        logic [39:0] q_cc [QDEPTH];
        int          q_head, q_cnt;
        logic        fl_valid;
        logic [31:0] fl_seq;
        logic [39:0] fl_cc;
        logic [3:0]  fl_att;
        logic [31:0] fl_serial;
        logic [31:0] serial_ctr, seq_ctr;
        logic        tmr_armed;
        logic [15:0] tmr_cnt;
        t_out_item   pending [$];
        t_out_item   batch [$];
        int          errors;

        function new();
            rt_valid = 0; rt_node = 0; max_att = 3; tmo_ticks = 1000;
            q_head = 0; q_cnt = 0; fl_valid = 0; fl_seq = 0; fl_cc = 0;
            fl_att = 0; fl_serial = 0; serial_ctr = 0; seq_ctr = 0;
            tmr_armed = 0; tmr_cnt = 0; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_ROUTE_VALID: rt_valid = val[0];
                CFG_ROUTE_NODE:  rt_node = val[5:0];
                CFG_MAX_ATT:     max_att = val[3:0];
                default:         tmo_ticks = val;
            endcase
        endfunction

        function void put(logic [1:0] kind, logic [31:0] seq, logic [39:0] cc,
                          logic [5:0] node, logic [3:0] att, logic [31:0] ser,
                          logic [3:0] st);
            t_out_item r;
            r = '0;
            r.kind = kind; r.seqnum = seq; r.out_category = cc[39:32];
            r.out_command = cc[31:0]; r.target_node = node; r.attempt = att;
            r.send_serial = ser; r.status = st;
            batch.insert(batch.size(), r);
        endfunction

        function void finish_flight(logic [3:0] st);
            fl_valid = 0; tmr_armed = 0; tmr_cnt = 0;
            put(KIND_CMPL, fl_seq, fl_cc, 0, 0, 0, st);
        endfunction

        function void send_flight();
            fl_att = fl_att + 1;
            serial_ctr = serial_ctr + 1;
            fl_serial = serial_ctr;
            tmr_armed = 0; tmr_cnt = 0;
            put(KIND_SEND, fl_seq, fl_cc, rt_node, fl_att, fl_serial, ST_OK);
        endfunction

        function void resend_or_fail();
            if (fl_att < max_att) send_flight();
            else finish_flight(ST_TIMEOUT);
        endfunction

        function void launch_next();
            while (!fl_valid && q_cnt > 0) begin
                int h;
                h = q_head;
                q_head = (h + 1) % QDEPTH;
                q_cnt--;
                if (!rt_valid) begin
                    put(KIND_CMPL, q_seq[h], q_cc[h], 0, 0, 0, ST_NOTREADY);
                end else begin
                    fl_valid = 1; fl_seq = q_seq[h]; fl_cc = q_cc[h]; fl_att = 0;
                    send_flight();
                end
            end
        endfunction

        // Note an accepted input item: predict its results.
        function void note_input(t_in_item it);
            logic acc;
            logic [3:0] st;
            acc = 0;
            batch.delete();
            case (it.mode)
                MODE_SUBMIT: begin
                    logic [31:0] seq;
                    seq = seq_ctr;
                    seq_ctr = seq_ctr + SEQ_STEP_DEF;
                    if (q_cnt >= QDEPTH) begin
                        put(KIND_CMPL, seq, {it.category, it.command}, 0, 0, 0, ST_FULL);
                    end else begin
                        int idx;
                        idx = (q_head + q_cnt) % QDEPTH;
                        q_seq[idx] = seq;
                        q_cc[idx] = {it.category, it.command};
                        q_cnt++;
                        launch_next();
                    end
                end
                MODE_WDONE: begin
                    if (fl_valid && it.serial_tag == fl_serial) begin
                        case (it.write_result)
                            WR_OK: begin
                                tmr_armed = 1; tmr_cnt = tmo_ticks;
                            end
                            WR_TIMEOUT, WR_BUSY: resend_or_fail();
                            WR_STALE: finish_flight(ST_STALE);
                            WR_ABORTED: finish_flight(ST_ABORTED);
                            default: finish_flight(ST_IOERR);
                        endcase
                        launch_next();
                    end
                end
                MODE_TICK: begin
                    if (fl_valid && tmr_armed) begin
                        if (tmr_cnt <= 1) begin
                            tmr_armed = 0; tmr_cnt = 0;
                            resend_or_fail();
                            launch_next();
                        end else begin
                            tmr_cnt--;
                        end
                    end
                end
                MODE_RESP: begin
                    if (fl_valid && rt_valid && it.source_node[5:0] == rt_node &&
                        it.resp_seqnum == fl_seq + 32'd1) begin
                        acc = 1;
                        st = ST_OK;
                        if (it.resp_category != fl_cc[39:32] ||
                            it.resp_command != fl_cc[31:0])
                            st = ST_MISMATCH;
                        else if (it.resp_status != 0)
                            st = ST_DEVERR;
                        finish_flight(st);
                        launch_next();
                    end
                end
                MODE_CANCEL: begin
                    st = (it.cancel_status > 8) ? ST_ABORTED : it.cancel_status;
                    if (fl_valid) finish_flight(st);
                    while (q_cnt > 0) begin
                        put(KIND_CMPL, q_seq[q_head], q_cc[q_head], 0, 0, 0, st);
                        q_head = (q_head + 1) % QDEPTH;
                        q_cnt--;
                    end
                    q_head = 0; tmr_armed = 0; tmr_cnt = 0;
                end
                default: ;
            endcase
            if (batch.size() == 0) put(KIND_ACK, 0, 0, 0, 0, 0, ST_OK);
            foreach (batch[k]) begin
                batch[k].accepted = acc;
                batch[k].last = (k == batch.size() - 1);
                pending.insert(pending.size(), batch[k]);
            end
        endfunction

        // Check an accepted result against the oldest expectation.
        function void check_result(t_out_item got);
            t_out_item exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result item %p", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind) begin
                $error("kind: expected %0d actual %0d", exp_r.kind, got.kind); errors++;
            end
            if (got.seqnum !== exp_r.seqnum) begin
                $error("seqnum: expected %0h actual %0h", exp_r.seqnum, got.seqnum);
                errors++;
            end
            if (got.out_category !== exp_r.out_category) begin
                $error("out_category: expected %0h actual %0h",
                       exp_r.out_category, got.out_category); errors++;
            end
            if (got.out_command !== exp_r.out_command) begin
                $error("out_command: expected %0h actual %0h",
                       exp_r.out_command, got.out_command); errors++;
            end
            if (got.target_node !== exp_r.target_node) begin
                $error("target_node: expected %0d actual %0d",
                       exp_r.target_node, got.target_node); errors++;
            end
            if (got.attempt !== exp_r.attempt) begin
                $error("attempt: expected %0d actual %0d", exp_r.attempt, got.attempt);
                errors++;
            end
            if (got.send_serial !== exp_r.send_serial) begin
                $error("send_serial: expected %0h actual %0h",
                       exp_r.send_serial, got.send_serial); errors++;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d actual %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.accepted !== exp_r.accepted) begin
                $error("accepted: expected %0b actual %0b", exp_r.accepted, got.accepted);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $error("last: expected %0b actual %0b", exp_r.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = CFG_ROUTE_VALID;
    logic [15:0] i_cfg_data = '0;

    ctre_if #(.W($bits(t_in_item)))  cmd_ch ();
    ctre_if #(.W($bits(t_out_item))) res_ch ();

    command_transaction_retry_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (cmd_ch.sink),
        .out_ch      (res_ch.source)
    );

    retry_scoreboard sb = new();

    always #2 i_clk = ~i_clk;

    initial begin
        cmd_ch.valid = 0;
        cmd_ch.data  = '0;
        res_ch.ready = 0;
    end

    // Receiver side: random stalls, and one long hold-off on request.
    logic hold_off = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(t_out_item'(res_ch.data));
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                res_ch.ready <= 0;
                repeat (200) @(posedge i_clk);   // long back-pressure stretch
                hold_off = 0;
            end
            res_ch.ready <= 1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            // mostly no stall, sometimes short, rarely long
            gap = ($urandom_range(0, 9) < 5) ? 0 :
                  ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
                  $urandom_range(10, STALL_MAX);
            if (gap > 0) begin
                res_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Watchdog: cycles without any handshake.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Offer one item; holds valid until accepted, then random gap.
    task automatic send_item(t_in_item it, bit allow_gap = 1);
        int gap;
        cmd_ch.valid <= 1;
        cmd_ch.data  <= it;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sb.note_input(it);
        gap = 0;
        if (allow_gap && $urandom_range(0, 9) < 4)
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                             : $urandom_range(8, 25);
        if (gap > 0) begin
            cmd_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        cmd_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);   // let the tail of a cancel settle
    endtask

    function automatic t_in_item rand_fields();
        t_in_item it;
        it = '0;
        it.category      = $urandom;
        it.command       = $urandom;
        it.write_result  = $urandom_range(0, 7);
        it.serial_tag    = $urandom;
        it.source_node   = $urandom;
        it.resp_seqnum   = $urandom;
        it.resp_category = $urandom;
        it.resp_command  = $urandom;
        it.resp_status   = $urandom;
        it.cancel_status = $urandom_range(0, 15);
        return it;
    endfunction

    function automatic t_in_item mk(logic [2:0] mode);
        t_in_item it;
        it = rand_fields();
        it.mode = mode;
        return it;
    endfunction

    // Well-formed item built from predictor state, or noise.
    function automatic t_in_item pick_item();
        t_in_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            it = mk(MODE_SUBMIT);
        end else if (r < 55) begin
            it = mk(MODE_WDONE);
            if ($urandom_range(0, 9) < 8) it.serial_tag = sb.fl_serial;
            if ($urandom_range(0, 9) < 5) it.write_result = WR_OK;
        end else if (r < 70) begin
            it = mk(MODE_TICK);
        end else if (r < 88) begin
            it = mk(MODE_RESP);
            if ($urandom_range(0, 9) < 8) begin
                it.source_node[5:0] = sb.rt_node;
                it.resp_seqnum = sb.fl_seq + 32'd1;
                if ($urandom_range(0, 9) < 7) begin
                    it.resp_category = sb.fl_cc[39:32];
                    it.resp_command  = sb.fl_cc[31:0];
                end
                if ($urandom_range(0, 9) < 6) it.resp_status = 0;
            end
        end else if (r < 95) begin
            it = mk(MODE_CANCEL);
        end else begin
            it = mk(3'($urandom_range(5, 7)));
        end
        return it;
    endfunction

    initial begin
        t_in_item it;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: route invalid, so submits complete as not ready.
        it = mk(MODE_SUBMIT); it.category = 8'hFF; it.command = '1; send_item(it);
        it = mk(MODE_SUBMIT); it.category = 0; it.command = 0; send_item(it);
        send_item(mk(MODE_TICK));
        it = mk(MODE_WDONE); it.serial_tag = 0; send_item(it);    // nothing in flight
        send_item(mk(3'd7));                                      // unknown mode
        drain();

        cfg_write(CFG_ROUTE_VALID, 1);
        cfg_write(CFG_ROUTE_NODE, 63);
        cfg_write(CFG_MAX_ATT, 2);
        cfg_write(CFG_TIMEOUT, 0);                                // zero timeout
        send_item(mk(MODE_SUBMIT));
        it = mk(MODE_WDONE); it.serial_tag = sb.fl_serial + 1; send_item(it); // stale
        it = mk(MODE_WDONE); it.serial_tag = sb.fl_serial; it.write_result = WR_OK;
        send_item(it);
        send_item(mk(MODE_TICK));                                 // expire, resend
        it = mk(MODE_WDONE); it.serial_tag = sb.fl_serial; it.write_result = WR_BUSY;
        send_item(it);                                            // out of attempts
        // fill queue behind an in-flight command, then overflow
        for (int k = 0; k < QDEPTH + 2; k++) send_item(mk(MODE_SUBMIT));
        it = mk(MODE_CANCEL); it.cancel_status = 4'hF; send_item(it);
        send_item(mk(MODE_SUBMIT));
        it = mk(MODE_RESP); it.source_node = 16'hFFFF; it.resp_seqnum = sb.fl_seq + 1;
        it.resp_category = sb.fl_cc[39:32]; it.resp_command = sb.fl_cc[31:0];
        it.resp_status = 32'hFFFF_FFFF; send_item(it);            // device error
        it = mk(MODE_SUBMIT); send_item(it);
        it = mk(MODE_WDONE); it.serial_tag = sb.fl_serial; it.write_result = 3'd7;
        send_item(it);                                            // unknown result
        drain();

        // Random phases over several settings.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_MAX_ATT, 15); cfg_write(CFG_TIMEOUT, 16'hFFFF);
                    cfg_write(CFG_ROUTE_NODE, 0);
                end
                1: begin
                    cfg_write(CFG_MAX_ATT, 0); cfg_write(CFG_TIMEOUT, 1);
                    cfg_write(CFG_ROUTE_NODE, 6'($urandom));
                end
                2: begin
                    cfg_write(CFG_MAX_ATT, 1); cfg_write(CFG_TIMEOUT, 3);
                end
                3: cfg_write(CFG_ROUTE_VALID, 0);                 // route lost
                default: begin
                    cfg_write(CFG_ROUTE_VALID, 1); cfg_write(CFG_MAX_ATT, 3);
                    cfg_write(CFG_TIMEOUT, 2);
                end
            endcase
            if (ph == 2) begin
                // Long receiver hold-off while the sender keeps pushing.
                hold_off = 1;
                for (int k = 0; k < 12; k++) send_item(mk(MODE_SUBMIT), 0);
            end
            for (int k = 0; k < 15; k++) send_item(pick_item());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
sv/ctre_pkg.sv
sv/ctre_if.sv
sv/ctre_ram.sv
sv/command_transaction_retry_engine_core.sv
sv/ctre_checker.sv
tb/tb_command_transaction_retry_engine_core.sv
